### rtl/bdq_pkg.sv
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_DUMP       = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [DATA_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic [1:0]               status;
      logic                     last_item;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic dump_first;
      logic dump_next;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
   } dp_status_type;

   // Registered response control from the controller.
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       last;
      logic       use_data;
   } rsp_ctl_type;

endpackage

### rtl/bdq_ctrl.sv
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    opcode,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd,
   output rsp_ctl_type   rsp_ctl,
   output logic          busy
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type   state_ff, state_in;
   rsp_ctl_type rsp_ctl_ff, rsp_ctl_in;

   always_comb begin
      state_in   = state_ff;
      dp_cmd     = '0;
      rsp_ctl_in = '{valid: 1'b0, status: ST_OK, last: 1'b0, use_data: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     dp_cmd.push_front = (opcode == OP_PUSH_FRONT) && !dp_status.full;
                     dp_cmd.push_back  = (opcode == OP_PUSH_BACK) && !dp_status.full;
                     rsp_ctl_in.valid  = 1'b1;
                     rsp_ctl_in.status = dp_status.full ? ST_FULL : ST_OK;
                     rsp_ctl_in.last   = 1'b1;
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     dp_cmd.pop_front    = (opcode == OP_POP_FRONT) && !dp_status.empty;
                     dp_cmd.pop_back     = (opcode == OP_POP_BACK) && !dp_status.empty;
                     rsp_ctl_in.valid    = 1'b1;
                     rsp_ctl_in.status   = dp_status.empty ? ST_EMPTY : ST_OK;
                     rsp_ctl_in.last     = 1'b1;
                     rsp_ctl_in.use_data = !dp_status.empty;
                  end
                  OP_DUMP: begin
                     rsp_ctl_in.valid = 1'b1;
                     if (dp_status.empty) begin
                        rsp_ctl_in.status = ST_EMPTY;
                        rsp_ctl_in.last   = 1'b1;
                     end else begin
                        dp_cmd.dump_first   = 1'b1;
                        rsp_ctl_in.use_data = 1'b1;
                        rsp_ctl_in.last     = dp_status.dump_last;
                        if (!dp_status.dump_last) begin
                           state_in = S_DUMP;
                        end
                     end
                  end
                  default: begin
                     // Unused opcodes are dropped without a result.
                  end
               endcase
            end
         end
         S_DUMP: begin
            dp_cmd.dump_next    = 1'b1;
            rsp_ctl_in.valid    = 1'b1;
            rsp_ctl_in.use_data = 1'b1;
            rsp_ctl_in.last     = dp_status.dump_last;
            if (dp_status.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_ctl_ff <= '{valid: 1'b0, status: ST_OK, last: 1'b0, use_data: 1'b0};
      end else begin
         state_ff   <= state_in;
         rsp_ctl_ff <= rsp_ctl_in;
      end
   end

   assign busy    = (state_ff == S_DUMP);
   assign rsp_ctl = rsp_ctl_ff;

`ifndef ASSERT_OFF
   a_item_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (opcode <= OP_DUMP)) |=> rsp_ctl_ff.valid)
      else $error("accepted item produced no result");

   a_dump_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> rsp_ctl_ff.valid)
      else $error("dump cycle produced no result");

   a_not_last_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_ctl_ff.valid && !rsp_ctl_ff.last) |=> rsp_ctl_ff.valid)
      else $error("dump sequence ended without a last result");
`endif

endmodule

### rtl/bdq_datapath.sv
module bdq_datapath
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] push_value,
   input  dp_cmd_type               dp_cmd,
   output dp_status_type            dp_status,
   output logic signed [DATA_W-1:0] rd_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] dump_idx_ff, dump_idx_in;

   logic [IDX_W-1:0] cur_idx;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] tail_wr_addr;
   logic [IDX_W-1:0] tail_rd_addr;
   logic [IDX_W-1:0] dump_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic             rd_en;

   // Ring addition; both operands are below DEPTH, so one subtract wraps it.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(DEPTH)) begin
         s = s - (IDX_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   assign cur_idx      = dp_cmd.dump_first ? '0 : dump_idx_ff;
   assign front_dec    = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc    = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign tail_wr_addr = ring_add(front_ff, count_ff[IDX_W-1:0]);
   assign tail_rd_addr = ring_add(front_ff, IDX_W'(count_ff - 1'b1));
   assign dump_addr    = ring_add(front_ff, cur_idx);

   assign dp_status.empty     = (count_ff == '0);
   assign dp_status.full      = (count_ff == CNT_W'(DEPTH));
   assign dp_status.dump_last = ((CNT_W'(cur_idx) + 1'b1) == count_ff);

   assign wr_en   = dp_cmd.push_front || dp_cmd.push_back;
   assign wr_addr = dp_cmd.push_front ? front_dec : tail_wr_addr;
   assign rd_en   = dp_cmd.pop_front || dp_cmd.pop_back || dp_cmd.dump_first ||
                    dp_cmd.dump_next;

   always_comb begin
      priority if (dp_cmd.pop_front) begin
         rd_addr = front_ff;
      end else if (dp_cmd.pop_back) begin
         rd_addr = tail_rd_addr;
      end else begin
         rd_addr = dump_addr;
      end
   end

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      if (dp_cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + 1'b1;
      end
      if (dp_cmd.push_back) begin
         count_in = count_ff + 1'b1;
      end
      if (dp_cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - 1'b1;
      end
      if (dp_cmd.pop_back) begin
         count_in = count_ff - 1'b1;
      end
      if (dp_cmd.dump_first || dp_cmd.dump_next) begin
         dump_idx_in = cur_idx + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         dump_idx_ff <= '0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         dump_idx_ff <= dump_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.push_front || dp_cmd.push_back) |-> !dp_status.full)
      else $error("push issued into a full queue");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !dp_status.empty)
      else $error("read issued on an empty queue");
`endif

endmodule

### rtl/bounded_deque_unit.sv
// Bounded double-ended queue of signed 32-bit words held in a ring memory of
// DEPTH entries. A word is accepted on a rising edge where start is high and
// busy is low; its opcode selects push front, push back, pop front, pop back
// or dump. Every push and pop is answered by exactly one result word in the
// cycle after acceptance, and busy stays low, so a new word may be issued on
// every cycle. A dump of N stored entries emits N result words, one per
// cycle, front to back, the first in the cycle after acceptance; busy is
// high while the remaining entries are read, since the single read port of
// the ring memory delivers one entry per cycle. A dump of an empty
// queue gives one result with the empty status. Results appear for exactly
// one cycle, flagged by rsp_valid; the receiver cannot stall them and must
// take each one as it comes. The last result caused by a word carries
// last_item. A push into a full queue drops the value and reports full; a pop
// of an empty queue reports empty with a zero value. Opcodes above dump are
// ignored and give no result.
module bounded_deque_unit
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   dp_cmd_type               dp_cmd;
   dp_status_type            dp_status;
   rsp_ctl_type              rsp_ctl;
   logic signed [DATA_W-1:0] rd_data;

   // The controller decodes the opcode against the queue status and drives
   // the pointer, write and read commands; it also registers the response
   // control so it lines up with the registered memory read data.
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_word.opcode),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .rsp_ctl   (rsp_ctl),
      .busy      (busy)
   );

   // The datapath holds the ring memory, the front pointer, the entry count
   // and the dump index.
   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .push_value (req_word.value),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rd_data    (rd_data)
   );

   // Push and status-only results carry a zero value; pops and dump entries
   // take the word read from the memory on the previous edge.
   assign rsp_valid          = rsp_ctl.valid;
   assign rsp_word.out_value = rsp_ctl.use_data ? rd_data : '0;
   assign rsp_word.status    = rsp_ctl.status;
   assign rsp_word.last_item = rsp_ctl.last;

endmodule
